// File: rtl/rtmc_pkg.sv
// ----------------------------------------------------------------------------
// rtmc_pkg
// Shared constants and types for the radar track multirotor classifier.
// ----------------------------------------------------------------------------
package rtmc_pkg;

  localparam int unsigned CordicItersDef = 16;
  localparam int unsigned AtanDepth      = 24;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_REBUILD_GAP  = 3'd0,
    CFG_LOST_TIMEOUT = 3'd1,
    CFG_CONFIRM_HITS = 3'd2,
    CFG_MIN_SPEED    = 3'd3,
    CFG_MAX_SPEED    = 3'd4,
    CFG_MIN_AGE      = 3'd5,
    CFG_HOVER_VAR    = 3'd6,
    CFG_HEAD_LIMIT   = 3'd7
  } cfg_idx_e;

  // atan(2^-i) in 2^-16 degree
  localparam logic signed [25:0] AtanTab [AtanDepth] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
    26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
    26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

endpackage

// File: rtl/radar_track_multirotor_classifier.sv
// Sequence: a refresh word or a word that opens a new track goes from acceptance to S_FIN,
// which loads the output register when it is free; a full update runs two 27-step velocity
// divisions, 19-step square root, 27-step variance division, CORDIC_ITERS = 16 CORDIC steps,
// 27-step heading rate division; dt outside 1..999 ms skips the velocity and rate divisions.
// Throughput: one word at a time; input ready again the cycle after the result is loaded.
// Reset: asynchronous, active low; clears the track state and loads register defaults.
// ----------------------------------------------------------------------------
// radar_track_multirotor_classifier
// Single-target radar track with speed, variance, heading rate and a
// multirotor likeness score.
// ----------------------------------------------------------------------------
module radar_track_multirotor_classifier
  import rtmc_pkg::*;
#(
  parameter int unsigned CORDIC_ITERS = CordicItersDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[15:0], pos_y[31:16], now_ms[63:32]
  input  logic [63:0]  s_axis_tdata,
  // kind[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // track_number[15:0], active[16], confirmed[17], track_x[33:18],
  // track_y[49:34], vel_x[68:50], vel_y[87:69], hits[103:88], losses[119:104],
  // age_ms[151:120], score[158:152], multirotor_like[159]
  output logic [159:0] m_axis_tdata
);

  localparam logic [4:0] CordLast = 5'(CORDIC_ITERS - 1);
  localparam logic [4:0] DivLast  = 5'd26;
  localparam logic [4:0] SqrtLast = 5'd18;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_VX    = 12'b0000_0000_0010,
    S_VY    = 12'b0000_0000_0100,
    S_SQA   = 12'b0000_0000_1000,
    S_SQB   = 12'b0000_0001_0000,
    S_SQRT  = 12'b0000_0010_0000,
    S_VPREP = 12'b0000_0100_0000,
    S_VAR   = 12'b0000_1000_0000,
    S_CORD  = 12'b0001_0000_0000,
    S_HEAD  = 12'b0010_0000_0000,
    S_RATE  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [15:0] r_gap_q, r_lost_q;
  logic [7:0]  r_confirm_q;
  logic [17:0] r_minspd_q, r_maxspd_q;
  logic [31:0] r_minage_q;
  logic [21:0] r_hover_q, r_hlimit_q;

  // track state
  logic [15:0] next_num_q, next_num_d, trk_num_q, trk_num_d;
  logic [15:0] hits_q, hits_d, losses_q, losses_d;
  logic        act_q, act_d, conf_q, conf_d, mr_q, mr_d;
  logic signed [15:0] trk_x_q, trk_x_d, trk_y_q, trk_y_d;
  logic signed [15:0] meas_x_q, meas_x_d, meas_y_q, meas_y_d;
  logic signed [18:0] vx_q, vx_d, vy_q, vy_d;
  logic [31:0] first_q, first_d, last_seen_q, last_seen_d, last_meas_q, last_meas_d;
  logic [31:0] age_q, age_d;
  logic [21:0] svar_q, svar_d, hrate_q, hrate_d;
  logic [18:0] prev_spd_q, prev_spd_d;
  logic signed [12:0] prev_hdg_q, prev_hdg_d;
  logic [6:0]  score_q, score_d;

  // work registers
  logic [4:0]  cnt_q, cnt_d;
  logic [26:0] dnum_q, dnum_d;
  logic [9:0]  drem_q, drem_d, dden_q, dden_d;
  logic        neg_q, neg_d, dt_ok_q, dt_ok_d, sqgt1_q, sqgt1_d;
  logic [9:0]  dt_q, dt_d;
  logic signed [16:0] dy_q, dy_d;
  logic [31:0] now_q, now_d;
  logic [37:0] sq_q, sq_d;
  logic [20:0] srem_q, srem_d;
  logic [18:0] sroot_q, sroot_d, spd_q, spd_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [25:0] cz_q, cz_d;

  // output register
  logic         ovalid_q, ovalid_d;
  logic [159:0] odata_q, odata_d;

  // magnitude of d*1000 plus half of dt
  function automatic logic [26:0] vel_num(logic signed [16:0] d, logic [9:0] dt);
    logic [16:0] a;
    a = d[16] ? 17'(-d) : 17'(d);
    return 27'(a) * 27'd1000 + {18'b0, dt[9:1]};
  endfunction

  function automatic logic signed [18:0] vel_sat(logic [26:0] q, logic neg);
    logic signed [18:0] r;
    if (!neg) begin
      r = (q > 27'd262143) ? 19'sh3FFFF : $signed(q[18:0]);
    end else begin
      r = (q > 27'd262144) ? 19'sh40000 : $signed(19'(-q[18:0]));
    end
    return r;
  endfunction

  // shared divider step
  logic [10:0] d_sh;
  logic        d_ge;
  logic [9:0]  d_rem_n;
  logic [26:0] d_num_n;
  always_comb begin
    d_sh    = {drem_q, dnum_q[26]};
    d_ge    = d_sh >= {1'b0, dden_q};
    d_rem_n = d_ge ? 10'(d_sh - {1'b0, dden_q}) : d_sh[9:0];
    d_num_n = {dnum_q[25:0], d_ge};
  end

  // square root step, two bits a cycle
  logic [22:0] s_sh;
  logic [22:0] s_trial;
  logic        s_ge;
  logic [20:0] s_rem_n;
  logic [18:0] s_root_n;
  always_comb begin
    s_sh     = {srem_q, sq_q[37:36]};
    s_trial  = {2'b0, sroot_q, 2'b01};
    s_ge     = s_sh >= s_trial;
    s_rem_n  = s_ge ? 21'(s_sh - s_trial) : s_sh[20:0];
    s_root_n = {sroot_q[17:0], s_ge};
  end

  // squarer
  logic signed [18:0] mul_a;
  logic signed [37:0] prod;
  assign mul_a = (state_q == S_SQA) ? vx_q : vy_q;
  assign prod  = mul_a * mul_a;

  // CORDIC step
  logic signed [31:0] c_xs, c_ys;
  logic signed [25:0] c_ang;
  assign c_xs  = cx_q >>> cnt_q;
  assign c_ys  = cy_q >>> cnt_q;
  assign c_ang = AtanTab[cnt_q];

  logic s_fire, m_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = ovalid_q && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  logic signed [15:0] in_x, in_y;
  logic [31:0] in_now, gap, dt32, age_n;
  logic signed [16:0] in_dx;
  logic [37:0] sq_sum;
  logic [18:0] delta;
  logic [26:0] vq;
  logic signed [25:0] zr;
  logic signed [12:0] hdg_n;
  logic signed [13:0] hdiff;
  logic [12:0] had;
  logic [11:0] hd;

  always_comb begin
    state_d = state_q;
    next_num_d = next_num_q; trk_num_d = trk_num_q;
    hits_d = hits_q; losses_d = losses_q;
    act_d = act_q; conf_d = conf_q; mr_d = mr_q;
    trk_x_d = trk_x_q; trk_y_d = trk_y_q;
    meas_x_d = meas_x_q; meas_y_d = meas_y_q;
    vx_d = vx_q; vy_d = vy_q;
    first_d = first_q; last_seen_d = last_seen_q; last_meas_d = last_meas_q;
    age_d = age_q; svar_d = svar_q; hrate_d = hrate_q;
    prev_spd_d = prev_spd_q; prev_hdg_d = prev_hdg_q; score_d = score_q;
    cnt_d = cnt_q; dnum_d = dnum_q; drem_d = drem_q; dden_d = dden_q;
    neg_d = neg_q; dt_ok_d = dt_ok_q; sqgt1_d = sqgt1_q; dt_d = dt_q;
    dy_d = dy_q; now_d = now_q; sq_d = sq_q; srem_d = srem_q; sroot_d = sroot_q;
    spd_d = spd_q; cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d = odata_q;

    in_x   = $signed(s_axis_tdata[15:0]);
    in_y   = $signed(s_axis_tdata[31:16]);
    in_now = s_axis_tdata[63:32];
    gap    = in_now - last_seen_q;
    dt32   = in_now - last_meas_q;
    in_dx  = 17'(in_x) - 17'(meas_x_q);
    sq_sum = sq_q + 38'(prod);
    delta  = (spd_q > prev_spd_q) ? spd_q - prev_spd_q : prev_spd_q - spd_q;
    vq     = d_num_n;
    zr     = (cz_q + 26'sd2048) >>> 12;
    if (!sqgt1_q) begin
      hdg_n = prev_hdg_q;
    end else if (zr > 26'sd2880) begin
      hdg_n = 13'sd2880;
    end else if (zr < -26'sd2880) begin
      hdg_n = -13'sd2880;
    end else begin
      hdg_n = zr[12:0];
    end
    hdiff = 14'(hdg_n) - 14'(prev_hdg_q);
    had   = hdiff[13] ? 13'(-hdiff) : 13'(hdiff);
    hd    = (had > 13'd2880) ? 12'(13'd5760 - had) : had[11:0];
    age_n = (now_q >= first_q) ? now_q - first_q : 32'd0;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          now_d = in_now;
          if (!s_axis_tuser) begin
            if (!act_q || gap > {16'b0, r_gap_q}) begin
              trk_num_d = next_num_q;
              next_num_d = next_num_q + 16'd1;
              act_d = 1'b1; conf_d = 1'b0; mr_d = 1'b0;
              vx_d = '0; vy_d = '0;
              hits_d = 16'd1; losses_d = '0;
              first_d = in_now; last_seen_d = in_now;
              score_d = '0; age_d = '0; svar_d = '0; hrate_d = '0;
              prev_spd_d = '0; prev_hdg_d = '0;
              state_d = S_FIN;
            end else begin
              dt_ok_d = (dt32 != 32'd0) && (dt32 < 32'd1000);
              dt_d = dt32[9:0];
              dy_d = 17'(in_y) - 17'(meas_y_q);
              last_seen_d = in_now;
              losses_d = '0;
              hits_d = (hits_q == 16'hFFFF) ? hits_q : hits_q + 16'd1;
              conf_d = hits_d >= {8'b0, r_confirm_q};
              if ((dt32 != 32'd0) && (dt32 < 32'd1000)) begin
                dnum_d = vel_num(in_dx, dt32[9:0]);
                dden_d = dt32[9:0];
                drem_d = '0;
                neg_d  = in_dx[16];
                cnt_d  = '0;
                state_d = S_VX;
              end else begin
                vx_d = '0; vy_d = '0;
                state_d = S_SQA;
              end
            end
            trk_x_d = in_x; trk_y_d = in_y;
            meas_x_d = in_x; meas_y_d = in_y; last_meas_d = in_now;
          end else begin
            if (act_q && gap > {16'b0, r_lost_q}) begin
              act_d = 1'b0; conf_d = 1'b0;
              losses_d = (losses_q == 16'hFFFF) ? losses_q : losses_q + 16'd1;
              vx_d = '0; vy_d = '0; mr_d = 1'b0; score_d = '0;
            end
            state_d = S_FIN;
          end
        end
      end
      S_VX, S_VY, S_VAR, S_RATE: begin
        dnum_d = d_num_n;
        drem_d = d_rem_n;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == DivLast) begin
          cnt_d  = '0;
          drem_d = '0;
          if (state_q == S_VX) begin
            vx_d   = vel_sat(vq, neg_q);
            dnum_d = vel_num(dy_q, dt_q);
            neg_d  = dy_q[16];
            state_d = S_VY;
          end else if (state_q == S_VY) begin
            vy_d = vel_sat(vq, neg_q);
            state_d = S_SQA;
          end else if (state_q == S_VAR) begin
            svar_d = (vq > 27'd4194303) ? 22'h3FFFFF : vq[21:0];
            if (sqgt1_q) begin
              // pre-rotate into the right half plane
              if (vy_q < 0) begin
                if (vx_q >= 0) begin
                  cx_d = 32'(vx_q) <<< 8;
                  cy_d = -(32'(vy_q) <<< 8);
                  cz_d = 26'sd5898240;
                end else begin
                  cx_d = -(32'(vx_q) <<< 8);
                  cy_d = 32'(vy_q) <<< 8;
                  cz_d = -26'sd5898240;
                end
              end else begin
                cx_d = 32'(vy_q) <<< 8;
                cy_d = 32'(vx_q) <<< 8;
                cz_d = '0;
              end
              state_d = S_CORD;
            end else begin
              state_d = S_HEAD;
            end
          end else begin
            hrate_d = vq[21:0];
            state_d = S_FIN;
          end
        end
      end
      S_SQA: begin
        sq_d = 38'(prod);
        state_d = S_SQB;
      end
      S_SQB: begin
        sq_d    = sq_sum;
        sqgt1_d = sq_sum > 38'd1;
        srem_d  = '0;
        sroot_d = '0;
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        sq_d    = {sq_q[35:0], 2'b00};
        srem_d  = s_rem_n;
        sroot_d = s_root_n;
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == SqrtLast) begin
          // round to nearest: remainder above root means past the half
          spd_d = s_root_n + 19'(s_rem_n > {2'b0, s_root_n});
          cnt_d = '0;
          state_d = S_VPREP;
        end
      end
      S_VPREP: begin
        dnum_d = {3'b0, svar_q, 2'b00} + {4'b0, delta, 4'b0000} + 27'd2;
        dden_d = 10'd5;
        drem_d = '0;
        cnt_d  = '0;
        state_d = S_VAR;
      end
      S_CORD: begin
        if (cy_q >= 0) begin
          cx_d = cx_q + c_ys; cy_d = cy_q - c_xs; cz_d = cz_q + c_ang;
        end else begin
          cx_d = cx_q - c_ys; cy_d = cy_q + c_xs; cz_d = cz_q - c_ang;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == CordLast) begin
          cnt_d = '0;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        // features that do not wait on the heading rate
        prev_spd_d = spd_q;
        prev_hdg_d = hdg_n;
        age_d = age_n;
        if (dt_ok_q) begin
          dnum_d = 27'(hd) * 27'd1000 + {18'b0, dt_q[9:1]};
          dden_d = dt_q;
          drem_d = '0;
          cnt_d  = '0;
          state_d = S_RATE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d = {mr_q, score_q, (act_q ? age_q : 32'd0), losses_q, hits_q,
                     vy_q, vx_q, trk_y_q, trk_x_q, conf_q, act_q, trk_num_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // score for an update, taken on the way into the output register
  logic [6:0]  sc_val;
  logic        sc_mr;
  logic signed [7:0] sc_raw;
  always_comb begin
    sc_raw = 8'sd0;
    if (prev_spd_q >= {1'b0, r_minspd_q} && prev_spd_q <= {1'b0, r_maxspd_q}) begin
      sc_raw = sc_raw + 8'sd35;
    end
    if (age_q >= r_minage_q) sc_raw = sc_raw + 8'sd30;
    if (svar_q <= r_hover_q) sc_raw = sc_raw + 8'sd20;
    if (hrate_q <= r_hlimit_q) begin
      sc_raw = sc_raw + 8'sd15;
    end else begin
      sc_raw = sc_raw - 8'sd15;
    end
    sc_val = (sc_raw < 0) ? 7'd0 : sc_raw[6:0];
    sc_mr  = (age_q >= r_minage_q) && (sc_val >= 7'd65);
  end

  // an update marks itself with upd_q so the score lands once, in S_FIN
  logic upd_q, upd_d;
  always_comb begin
    upd_d = upd_q;
    if (state_q == S_HEAD) upd_d = 1'b1;
    if (state_q == S_FIN) upd_d = 1'b0;
  end

  logic [6:0] score_f;
  logic       mr_f;
  assign score_f = upd_q ? sc_val : score_d;
  assign mr_f    = upd_q ? sc_mr : mr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_gap_q <= 16'd1000; r_lost_q <= 16'd1500; r_confirm_q <= 8'd3;
      r_minspd_q <= '0; r_maxspd_q <= 18'd5000; r_minage_q <= 32'd2000;
      r_hover_q <= 22'd3200; r_hlimit_q <= 22'd1440;
      next_num_q <= 16'd1; trk_num_q <= '0; hits_q <= '0; losses_q <= '0;
      act_q <= 1'b0; conf_q <= 1'b0; mr_q <= 1'b0;
      trk_x_q <= '0; trk_y_q <= '0; meas_x_q <= '0; meas_y_q <= '0;
      vx_q <= '0; vy_q <= '0;
      first_q <= '0; last_seen_q <= '0; last_meas_q <= '0; age_q <= '0;
      svar_q <= '0; hrate_q <= '0; prev_spd_q <= '0; prev_hdg_q <= '0;
      score_q <= '0; upd_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_REBUILD_GAP:  r_gap_q     <= cfg_wdata_i[15:0];
          CFG_LOST_TIMEOUT: r_lost_q    <= cfg_wdata_i[15:0];
          CFG_CONFIRM_HITS: r_confirm_q <= cfg_wdata_i[7:0];
          CFG_MIN_SPEED:    r_minspd_q  <= cfg_wdata_i[17:0];
          CFG_MAX_SPEED:    r_maxspd_q  <= cfg_wdata_i[17:0];
          CFG_MIN_AGE:      r_minage_q  <= cfg_wdata_i;
          CFG_HOVER_VAR:    r_hover_q   <= cfg_wdata_i[21:0];
          CFG_HEAD_LIMIT:   r_hlimit_q  <= cfg_wdata_i[21:0];
          default: ;
        endcase
      end
      next_num_q <= next_num_d; trk_num_q <= trk_num_d;
      hits_q <= hits_d; losses_q <= losses_d;
      act_q <= act_d; conf_q <= conf_d;
      trk_x_q <= trk_x_d; trk_y_q <= trk_y_d;
      meas_x_q <= meas_x_d; meas_y_q <= meas_y_d;
      vx_q <= vx_d; vy_q <= vy_d;
      first_q <= first_d; last_seen_q <= last_seen_d; last_meas_q <= last_meas_d;
      age_q <= age_d; svar_q <= svar_d; hrate_q <= hrate_d;
      prev_spd_q <= prev_spd_d; prev_hdg_q <= prev_hdg_d;
      upd_q <= upd_d;
      ovalid_q <= ovalid_d;
      if (state_q == S_FIN && upd_q) begin
        score_q <= score_f;
        mr_q    <= mr_f;
      end else begin
        score_q <= score_d;
        mr_q    <= mr_d;
      end
    end
  end

  // output word picks up the fresh score on an update, only when it is loaded
  logic [159:0] odata_f;
  always_comb begin
    odata_f = odata_d;
    if (state_q == S_FIN && upd_q && (!ovalid_q || m_axis_tready)) begin
      odata_f[158:152] = score_f;
      odata_f[159]     = mr_f;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; dnum_q <= dnum_d; drem_q <= drem_d; dden_q <= dden_d;
    neg_q <= neg_d; dt_ok_q <= dt_ok_d; sqgt1_q <= sqgt1_d; dt_q <= dt_d;
    dy_q <= dy_d; now_q <= now_d; sq_q <= sq_d; srem_q <= srem_d;
    sroot_q <= sroot_d; spd_q <= spd_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    odata_q <= odata_f;
  end

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!ovalid_q || m_axis_tready)) |=> ovalid_q)
    else $error("result lost on the way to the output register");
  a_score_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_q <= 7'd100)
    else $error("score above 100");
  a_lost_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_q |-> (!conf_q && !mr_q))
    else $error("inactive track still flagged");
  a_cord_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q < 5'(CORDIC_ITERS)))
    else $error("CORDIC step count overrun");

endmodule
